/* hdl/toq_pkg.sv */
// shared types and codes for the timestamp ordered event queue
package toq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] time_stamp;
    logic [7:0]  event_tag;
    logic [7:0]  proc_id;
    logic [2:0]  transition;
  } ev_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_time;
    logic [7:0]  out_tag;
    logic [7:0]  out_proc;
    logic [2:0]  out_transition;
    logic        head_valid;
    logic [31:0] head_time;
    logic [4:0]  occupancy;
  } res_item_t;

  // per-entry payload carried beside the timestamp
  typedef struct packed {
    logic [7:0] tag;
    logic [7:0] proc_id;
    logic [2:0] transition;
  } meta_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_MARK,
    CELL_SWAP_EVEN,
    CELL_SWAP_ODD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    meta_t    meta;
  } cell_cmd_t;

endpackage

/* hdl/timestamp_ordered_event_queue_top.sv */
// top level of the timestamp ordered event queue: cell chain and sequencer
//
//  channel | signals                 | beat carries
//  --------+-------------------------+-------------------------------
//  ev      | ev_valid, ev_ready, ev  | one operation (insert/pop/remove)
//  res     | res_valid, res_ready, res | status, popped event, head, count
//
// insert, pop and unused codes are answered from the idle state: one beat per clock while res drains.
// remove runs as a tag mark, QUEUE_DEPTH odd-even compaction
// phases across the cell chain, then a load of the result register.
// reset clears the entry count, the sequencer and the result valid flag; no clearing pass.
// a stalled res holds the finished result, blocks the next ev beat and holds a finished remove in its done state.
module timestamp_ordered_event_queue_top #(
  parameter int QUEUE_DEPTH = toq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = toq_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  output logic                ev_ready,
  input  toq_pkg::ev_item_t   ev,
  output logic                res_valid,
  input  logic                res_ready,
  output toq_pkg::res_item_t  res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PH_W  = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_DONE
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [PH_W-1:0]      phase;
  logic [QUEUE_DEPTH-1:0] match_sr;
  logic                 found;

  logic [TIME_BITS-1:0] slot_time [QUEUE_DEPTH];
  toq_pkg::meta_t       slot_meta [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hole;
  logic [QUEUE_DEPTH-1:0] later;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] at_end;
  logic [QUEUE_DEPTH-1:0] match;

  toq_pkg::cell_cmd_t   cmd;
  logic [TIME_BITS-1:0] key_time;
  logic                 accept;
  logic                 full;
  logic                 empty;
  toq_pkg::res_item_t   res_now;
  toq_pkg::res_item_t   res_done;

  assign ev_ready = (state == ST_IDLE) && (!res_valid || res_ready);
  assign accept   = ev_valid && ev_ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign key_time = TIME_BITS'(ev.time_stamp);
  assign match    = occ & hit;

  always_comb begin
    cmd.meta.tag        = ev.event_tag;
    cmd.meta.proc_id    = ev.proc_id;
    cmd.meta.transition = ev.transition;
    cmd.op              = toq_pkg::CELL_HOLD;
    if (state == ST_SORT) begin
      cmd.op = phase[0] ? toq_pkg::CELL_SWAP_ODD : toq_pkg::CELL_SWAP_EVEN;
    end else if (accept) begin
      case (ev.func)
        toq_pkg::FUNC_INSERT: cmd.op = full ? toq_pkg::CELL_HOLD : toq_pkg::CELL_INSERT;
        toq_pkg::FUNC_POP:    cmd.op = empty ? toq_pkg::CELL_HOLD : toq_pkg::CELL_POP;
        toq_pkg::FUNC_REMOVE: cmd.op = toq_pkg::CELL_MARK;
        default:              cmd.op = toq_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TIME_BITS-1:0] lt;
    toq_pkg::meta_t       lm;
    logic                 lh;
    logic                 lg;
    logic [TIME_BITS-1:0] rt;
    toq_pkg::meta_t       rm;
    logic                 rh;

    assign occ[i]    = (count > CNT_W'(i));
    assign at_end[i] = (count == CNT_W'(i));

    if (i > 0) begin : g_left
      assign lt = slot_time[i-1];
      assign lm = slot_meta[i-1];
      assign lh = hole[i-1];
      assign lg = later[i-1];
    end else begin : g_left_edge
      assign lt = '0;
      assign lm = '0;
      assign lh = 1'b0;
      assign lg = 1'b0;
    end

    if (i < QUEUE_DEPTH - 1) begin : g_right
      assign rt = slot_time[i+1];
      assign rm = slot_meta[i+1];
      assign rh = hole[i+1];
    end else begin : g_right_edge
      assign rt = '0;
      assign rm = '0;
      assign rh = 1'b1;
    end

    toq_cell #(
      .TIME_BITS(TIME_BITS),
      .DEPTH    (QUEUE_DEPTH),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key_time  (key_time),
      .occ       (occ[i]),
      .at_end    (at_end[i]),
      .left_time (lt),
      .left_meta (lm),
      .left_hole (lh),
      .left_later(lg),
      .right_time(rt),
      .right_meta(rm),
      .right_hole(rh),
      .slot_time (slot_time[i]),
      .slot_meta (slot_meta[i]),
      .hole      (hole[i]),
      .later     (later[i]),
      .hit       (hit[i])
    );
  end

  // result of an insert, pop or unused code, built from the chain before it updates
  always_comb begin
    res_now                = '0;
    res_now.status         = toq_pkg::STATUS_OK;
    res_now.head_valid     = !empty;
    res_now.head_time      = empty ? 32'd0 : 32'(slot_time[0]);
    res_now.occupancy      = 5'(count);
    case (ev.func)
      toq_pkg::FUNC_INSERT: begin
        if (full) begin
          res_now.status = toq_pkg::STATUS_FULL;
        end else begin
          res_now.head_valid = 1'b1;
          res_now.head_time  = (empty || later[0]) ? 32'(key_time) : 32'(slot_time[0]);
          res_now.occupancy  = 5'(count + CNT_W'(1));
        end
      end
      toq_pkg::FUNC_POP: begin
        if (empty) begin
          res_now.status = toq_pkg::STATUS_EMPTY;
        end else begin
          res_now.out_time       = 32'(slot_time[0]);
          res_now.out_tag        = slot_meta[0].tag;
          res_now.out_proc       = slot_meta[0].proc_id;
          res_now.out_transition = slot_meta[0].transition;
          res_now.head_valid     = (count > CNT_W'(1));
          res_now.head_time      = (count > CNT_W'(1)) ? 32'(slot_time[1]) : 32'd0;
          res_now.occupancy      = 5'(count - CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // result of a finished remove, taken from the compacted chain
  always_comb begin
    res_done            = '0;
    res_done.status     = found ? toq_pkg::STATUS_OK : toq_pkg::STATUS_NOTFOUND;
    res_done.head_valid = (count != '0);
    res_done.head_time  = (count != '0) ? 32'(slot_time[0]) : 32'd0;
    res_done.occupancy  = 5'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      phase     <= '0;
      found     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && ev.func != toq_pkg::FUNC_REMOVE) begin
            res       <= res_now;
            res_valid <= 1'b1;
            if (ev.func == toq_pkg::FUNC_INSERT && !full) begin
              count <= count + CNT_W'(1);
            end else if (ev.func == toq_pkg::FUNC_POP && !empty) begin
              count <= count - CNT_W'(1);
            end
          end else begin
            if (res_ready) begin
              res_valid <= 1'b0;
            end
            if (accept) begin
              state    <= ST_SORT;
              phase    <= '0;
              match_sr <= match;
              found    <= |match;
            end
          end
        end
        ST_SORT: begin
          phase    <= phase + PH_W'(1);
          match_sr <= match_sr >> 1;
          if (match_sr[0]) begin
            count <= count - CNT_W'(1);
          end
          if (phase == PH_W'(QUEUE_DEPTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            res       <= res_done;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/toq_cell.sv */
// one slot of the sorted chain: holds an entry and trades with its neighbors
module toq_cell #(
  parameter int TIME_BITS = toq_pkg::TIME_BITS_DEF,
  parameter int DEPTH     = toq_pkg::QUEUE_DEPTH_DEF,
  parameter int INDEX     = 0
) (
  input  logic                  clk,
  input  toq_pkg::cell_cmd_t    cmd,
  input  logic [TIME_BITS-1:0]  key_time,
  input  logic                  occ,
  input  logic                  at_end,
  input  logic [TIME_BITS-1:0]  left_time,
  input  toq_pkg::meta_t        left_meta,
  input  logic                  left_hole,
  input  logic                  left_later,
  input  logic [TIME_BITS-1:0]  right_time,
  input  toq_pkg::meta_t        right_meta,
  input  logic                  right_hole,
  output logic [TIME_BITS-1:0]  slot_time,
  output toq_pkg::meta_t        slot_meta,
  output logic                  hole,
  output logic                  later,
  output logic                  hit
);

  localparam bit HAS_LEFT  = (INDEX > 0);
  localparam bit HAS_RIGHT = (INDEX < DEPTH - 1);
  localparam bit IS_EVEN   = ((INDEX % 2) == 0);

  logic [TIME_BITS-1:0] slot_time_next;
  toq_pkg::meta_t       slot_meta_next;
  logic                 hole_next;
  logic                 pair_left;

  assign later = occ && (slot_time > key_time);
  assign hit   = (slot_meta.tag == cmd.meta.tag);

  always_comb begin
    slot_time_next = slot_time;
    slot_meta_next = slot_meta;
    hole_next      = hole;
    pair_left      = ((cmd.op == toq_pkg::CELL_SWAP_EVEN) == IS_EVEN);
    case (cmd.op)
      toq_pkg::CELL_INSERT: begin
        if (HAS_LEFT && left_later) begin
          slot_time_next = left_time;
          slot_meta_next = left_meta;
        end else if (later || at_end) begin
          slot_time_next = key_time;
          slot_meta_next = cmd.meta;
        end
      end
      toq_pkg::CELL_POP: begin
        if (HAS_RIGHT) begin
          slot_time_next = right_time;
          slot_meta_next = right_meta;
        end
      end
      toq_pkg::CELL_MARK: begin
        hole_next = !occ || hit;
      end
      toq_pkg::CELL_SWAP_EVEN, toq_pkg::CELL_SWAP_ODD: begin
        // odd-even transposition: a hole trades places with a kept entry to its right
        if (pair_left) begin
          if (HAS_RIGHT && hole && !right_hole) begin
            slot_time_next = right_time;
            slot_meta_next = right_meta;
            hole_next      = 1'b0;
          end
        end else begin
          if (HAS_LEFT && left_hole && !hole) begin
            slot_time_next = left_time;
            slot_meta_next = left_meta;
            hole_next      = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_time <= slot_time_next;
    slot_meta <= slot_meta_next;
    hole      <= hole_next;
  end

endmodule
